FILE: hw/rtl/nnpo_pkg.sv
package nnpo_pkg;

    // fixed field widths of the stream payload
    localparam int FIELD_W     = 16;
    localparam int INDEX_W     = 4;
    localparam int IN_TDATA_W  = 3 * FIELD_W;
    localparam int OUT_FIELD_W = 3 * FIELD_W + INDEX_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int PAD_W       = OUT_TDATA_W - OUT_FIELD_W;

    // microprogram steps
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_DRAIN_A,
        ST_DRAIN_B,
        ST_EMIT,
        ST_FINISH
    } step_t;

    // branch and hold conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_FINAL,
        C_OUT_BUSY,
        C_SCAN_MORE,
        C_MORE_POINTS
    } cond_t;

    // one control word
    typedef struct packed {
        logic  load_en;
        logic  scan_clr;
        logic  issue;
        logic  emit;
        logic  set_clr;
        cond_t hold;
        cond_t jump;
        step_t target;
    } uword_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic final_accept;
        logic out_busy;
        logic scan_more;
        logic more_points;
    } status_t;

    // control store
    function automatic uword_t ucode_rom(step_t s);
        uword_t w;
        w = '0;
        w.hold   = C_NEVER;
        w.jump   = C_NEVER;
        w.target = ST_LOAD;
        case (s)
            ST_LOAD: begin
                w.load_en = 1'b1;
                w.hold    = C_NO_FINAL;
            end
            ST_SCAN_INIT: begin
                w.scan_clr = 1'b1;
            end
            ST_SCAN: begin
                w.issue  = 1'b1;
                w.jump   = C_SCAN_MORE;
                w.target = ST_SCAN;
            end
            ST_DRAIN_A, ST_DRAIN_B: begin
                w.jump = C_NEVER;
            end
            ST_EMIT: begin
                w.emit   = 1'b1;
                w.hold   = C_OUT_BUSY;
                w.jump   = C_MORE_POINTS;
                w.target = ST_SCAN_INIT;
            end
            ST_FINISH: begin
                w.set_clr = 1'b1;
                w.jump    = C_ALWAYS;
                w.target  = ST_LOAD;
            end
            default: begin
                w.jump   = C_ALWAYS;
                w.target = ST_LOAD;
            end
        endcase
        return w;
    endfunction

    // condition evaluation
    function automatic logic cond_true(cond_t c, status_t st);
        logic r;
        case (c)
            C_NEVER:       r = 1'b0;
            C_ALWAYS:      r = 1'b1;
            C_NO_FINAL:    r = !st.final_accept;
            C_OUT_BUSY:    r = st.out_busy;
            C_SCAN_MORE:   r = st.scan_more;
            C_MORE_POINTS: r = st.more_points;
            default:       r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/nnpo_seq.sv
module nnpo_seq
    import nnpo_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  status_t status,
    output uword_t  uword
);

    step_t pc_reg;
    step_t pc_next;
    logic  hold_hit;
    logic  jump_hit;

    // control word of the current step
    assign uword    = ucode_rom(pc_reg);
    assign hold_hit = cond_true(uword.hold, status);
    assign jump_hit = cond_true(uword.jump, status);

    // step counter sequencing
    always_comb begin
        if (hold_hit) begin
            pc_next = pc_reg;
        end else if (jump_hit) begin
            pc_next = uword.target;
        end else begin
            pc_next = step_t'(pc_reg + 3'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= ST_LOAD;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: hw/rtl/nnpo_dp.sv
module nnpo_dp
    import nnpo_pkg::*;
#(
    parameter int MAX_POINTS = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  uword_t                 uword,
    output status_t                status,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    output logic                   m_tuser
);

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int SUM_W  = SQ_W + 2;
    localparam int DIST_W = (SUM_W > 64) ? 64 : SUM_W;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // point store
    coord_t mem_x [MAX_POINTS];
    coord_t mem_y [MAX_POINTS];
    coord_t mem_z [MAX_POINTS];

    // set state
    logic [CNT_W-1:0]      count_reg;
    logic                  dropped_reg;
    logic [MAX_POINTS-1:0] used_reg;
    coord_t                ref_x_reg, ref_y_reg, ref_z_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      k_reg;

    // scan pipeline
    logic                  rd_valid_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    coord_t                rd_x_reg, rd_y_reg, rd_z_reg;
    logic                  sq_valid_reg;
    logic [IDX_W-1:0]      sq_idx_reg;
    coord_t                sq_x_reg, sq_y_reg, sq_z_reg;
    logic [SQ_W-1:0]       sqx_reg, sqy_reg, sqz_reg;
    logic                  found_reg;
    logic [DIST_W-1:0]     best_d_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    coord_t                best_x_reg, best_y_reg, best_z_reg;

    // output register
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tlast_reg;
    logic                   m_tuser_reg;

    logic                    accept;
    logic                    room;
    logic                    emit_fire;
    logic                    better;
    coord_t                  in_x, in_y, in_z;
    logic [COORD_BITS-1:0]   ax, ay, az;
    logic [SUM_W-1:0]        sum;
    logic [DIST_W-1:0]       cand_d;

    function automatic logic [COORD_BITS-1:0] abs_diff(coord_t a, coord_t b);
        logic signed [COORD_BITS:0] d;
        d = (COORD_BITS + 1)'(a) - (COORD_BITS + 1)'(b);
        return d[COORD_BITS] ? COORD_BITS'(-d) : COORD_BITS'(d);
    endfunction

    // input side
    assign s_tready = uword.load_en;
    assign accept   = s_tvalid && s_tready;
    assign room     = count_reg < CNT_W'(MAX_POINTS);
    assign in_x     = COORD_BITS'($signed(s_tdata[FIELD_W-1:0]));
    assign in_y     = COORD_BITS'($signed(s_tdata[2*FIELD_W-1:FIELD_W]));
    assign in_z     = COORD_BITS'($signed(s_tdata[3*FIELD_W-1:2*FIELD_W]));

    // status back to the sequencer
    assign status.final_accept = accept && s_tlast;
    assign status.out_busy     = m_tvalid_reg && !m_tready;
    assign status.scan_more    = (CNT_W'(idx_reg) + CNT_W'(1)) != count_reg;
    assign status.more_points  = (k_reg + CNT_W'(1)) != count_reg;
    assign emit_fire           = uword.emit && !status.out_busy;

    // store write and scan read
    always_ff @(posedge aclk) begin
        if (accept && room) begin
            mem_x[count_reg[IDX_W-1:0]] <= in_x;
            mem_y[count_reg[IDX_W-1:0]] <= in_y;
            mem_z[count_reg[IDX_W-1:0]] <= in_z;
        end
        rd_x_reg <= mem_x[idx_reg];
        rd_y_reg <= mem_y[idx_reg];
        rd_z_reg <= mem_z[idx_reg];
    end

    // distance terms against the reference
    assign ax = abs_diff(rd_x_reg, ref_x_reg);
    assign ay = abs_diff(rd_y_reg, ref_y_reg);
    assign az = abs_diff(rd_z_reg, ref_z_reg);

    // sum of squares, saturated to 64 bits
    assign sum = SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
    generate
        if (SUM_W > 64) begin : g_sat
            assign cand_d = (|sum[SUM_W-1:64]) ? {DIST_W{1'b1}} : sum[DIST_W-1:0];
        end else begin : g_nosat
            assign cand_d = sum;
        end
    endgenerate

    // strict compare keeps the lowest index on ties
    assign better = sq_valid_reg && (!found_reg || cand_d < best_d_reg);

    // pipeline payload
    always_ff @(posedge aclk) begin
        rd_idx_reg <= idx_reg;
        sq_idx_reg <= rd_idx_reg;
        sq_x_reg   <= rd_x_reg;
        sq_y_reg   <= rd_y_reg;
        sq_z_reg   <= rd_z_reg;
        sqx_reg    <= SQ_W'(ax) * SQ_W'(ax);
        sqy_reg    <= SQ_W'(ay) * SQ_W'(ay);
        sqz_reg    <= SQ_W'(az) * SQ_W'(az);
        if (better) begin
            best_d_reg   <= cand_d;
            best_idx_reg <= sq_idx_reg;
            best_x_reg   <= sq_x_reg;
            best_y_reg   <= sq_y_reg;
            best_z_reg   <= sq_z_reg;
        end
        if (emit_fire) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, INDEX_W'(best_idx_reg),
                            FIELD_W'(best_z_reg), FIELD_W'(best_y_reg),
                            FIELD_W'(best_x_reg)};
            m_tlast_reg <= !status.more_points;
            m_tuser_reg <= dropped_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            used_reg     <= '0;
            ref_x_reg    <= '0;
            ref_y_reg    <= '0;
            ref_z_reg    <= '0;
            idx_reg      <= '0;
            k_reg        <= '0;
            rd_valid_reg <= 1'b0;
            sq_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                if (room) begin
                    count_reg <= count_reg + CNT_W'(1);
                end else begin
                    dropped_reg <= 1'b1;
                end
            end
            if (uword.scan_clr) begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            if (uword.issue) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            rd_valid_reg <= uword.issue && !used_reg[idx_reg];
            sq_valid_reg <= rd_valid_reg;
            if (better) begin
                found_reg <= 1'b1;
            end
            if (emit_fire) begin
                used_reg[best_idx_reg] <= 1'b1;
                ref_x_reg              <= best_x_reg;
                ref_y_reg              <= best_y_reg;
                ref_z_reg              <= best_z_reg;
                k_reg                  <= k_reg + CNT_W'(1);
            end
            if (uword.set_clr) begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
                used_reg    <= '0;
                ref_x_reg   <= '0;
                ref_y_reg   <= '0;
                ref_z_reg   <= '0;
                k_reg       <= '0;
            end
            if (emit_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count above capacity");

    a_emit_found: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire |-> found_reg)
        else $error("emit without a scanned candidate");

    a_emit_unused: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire |-> !used_reg[best_idx_reg])
        else $error("point emitted twice");

    a_load_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (k_reg == '0 && !rd_valid_reg && !sq_valid_reg))
        else $error("load beat taken while ordering is active");

endmodule

FILE: hw/rtl/nearest_neighbor_path_order.sv
// loading: one s_ beat per cycle while the loader step runs
// ordering: after the final point, each emitted point takes an init step, a scan
// of all n stored points through the distance pipeline, two drain steps and an
// emit step that holds while the output is stalled; the microcode scan loop reads
// one stored point at a time through the single store read port
// reset: aresetn synchronous active low, clears set state and the step counter
module nearest_neighbor_path_order
    import nnpo_pkg::*;
#(
    parameter int MAX_POINTS = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // pos_x, pos_y, pos_z
    input  logic                   s_tlast,   // last_point
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // out_x, out_y, out_z, load_index, zero pad
    output logic                   m_tlast,   // last_out
    output logic                   m_tuser    // overflow
);

    uword_t  uword;
    status_t status;

    // microcode sequencer
    nnpo_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .uword   (uword)
    );

    // store, distance pipeline and output register
    nnpo_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .uword    (uword),
        .status   (status),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: sim/nearest_neighbor_path_order_tb.sv
module nearest_neighbor_path_order_tb
    import nnpo_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY    = 16;
    localparam int HALF_PERIOD = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 60;

    // coordinate styles for random point sets
    typedef enum int {
        SPREAD_FULL,
        SPREAD_GRID,
        SPREAD_EDGE
    } spread_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        logic signed [FIELD_W-1:0] z;
        logic                      fin;
    } point_t;

    typedef struct packed {
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [FIELD_W-1:0] z;
        logic [INDEX_W-1:0] idx;
        logic               last;
        logic               ovf;
    } visit_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;

    // stimulus and expected visiting order
    point_t feed_q[$];
    visit_t tour_q[$];

    // mirror of the set held in the block
    logic signed [FIELD_W-1:0] set_x[CAPACITY];
    logic signed [FIELD_W-1:0] set_y[CAPACITY];
    logic signed [FIELD_W-1:0] set_z[CAPACITY];
    int                        set_count = 0;
    logic                      set_dropped = 1'b0;

    int idle_pct    = 0;
    int stall_pct   = 0;
    int hold_asked  = 0;
    int hold_served = 0;
    int hold_left   = 0;
    int err_cnt     = 0;
    int cycle_cnt   = 0;
    int queued      = 0;

    nearest_neighbor_path_order #(
        .MAX_POINTS(CAPACITY),
        .COORD_BITS(FIELD_W)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    initial begin
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // squared distance between a stored point and the current position
    function automatic longint unsigned dist_sq(int i, int rx, int ry, int rz);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'(set_x[i]) - rx;
        dy = longint'(set_y[i]) - ry;
        dz = longint'(set_z[i]) - rz;
        return longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
    endfunction

    // store a point; on the final one work out the greedy tour of the set
    task automatic absorb_point(point_t p);
        logic [CAPACITY-1:0] visited;
        int                  rx;
        int                  ry;
        int                  rz;
        int                  best;
        longint unsigned     best_d;
        longint unsigned     d;
        visit_t              v;
        if (set_count < CAPACITY) begin
            set_x[set_count] = p.x;
            set_y[set_count] = p.y;
            set_z[set_count] = p.z;
            set_count++;
        end else begin
            set_dropped = 1'b1;
        end
        if (!p.fin) return;
        visited = '0;
        rx = 0;
        ry = 0;
        rz = 0;
        for (int k = 0; k < set_count; k++) begin
            best = -1;
            best_d = 0;
            for (int i = 0; i < set_count; i++) begin
                if (visited[i]) continue;
                d = dist_sq(i, rx, ry, rz);
                // strict compare keeps the lowest index on a tie
                if (best < 0 || d < best_d) begin
                    best = i;
                    best_d = d;
                end
            end
            visited[best] = 1'b1;
            rx = set_x[best];
            ry = set_y[best];
            rz = set_z[best];
            v.x = set_x[best];
            v.y = set_y[best];
            v.z = set_z[best];
            v.idx = best[INDEX_W-1:0];
            v.last = (k == set_count - 1);
            v.ovf = set_dropped;
            tour_q.insert(tour_q.size(), v);
        end
        set_count = 0;
        set_dropped = 1'b0;
    endtask

    // sender: next point goes out once the current beat is taken
    always @(posedge aclk) begin
        point_t p;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                p.x = s_tdata[FIELD_W-1:0];
                p.y = s_tdata[2*FIELD_W-1:FIELD_W];
                p.z = s_tdata[3*FIELD_W-1:2*FIELD_W];
                p.fin = s_tlast;
                absorb_point(p);
            end
            if (!s_tvalid || s_tready) begin
                if (feed_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    p = feed_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {p.z, p.y, p.x};
                    s_tlast  <= p.fin;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left <= 0;
            hold_served <= 0;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic flag_field(string fname, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, fname, want, got);
            err_cnt++;
        end
    endtask

    // compare each output beat with the oldest expected visit
    always @(posedge aclk) begin
        visit_t got;
        visit_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.x = m_tdata[FIELD_W-1:0];
            got.y = m_tdata[2*FIELD_W-1:FIELD_W];
            got.z = m_tdata[3*FIELD_W-1:2*FIELD_W];
            got.idx = m_tdata[3*FIELD_W+INDEX_W-1:3*FIELD_W];
            got.last = m_tlast;
            got.ovf = m_tuser;
            if (tour_q.size() == 0) begin
                $display("%0t: unexpected beat expected none got %h", $time, got);
                err_cnt++;
            end else begin
                want = tour_q.pop_front();
                flag_field("out_x", want.x, got.x);
                flag_field("out_y", want.y, got.y);
                flag_field("out_z", want.z, got.z);
                flag_field("load_index", FIELD_W'(want.idx), FIELD_W'(got.idx));
                flag_field("last_out", FIELD_W'(want.last), FIELD_W'(got.last));
                flag_field("overflow", FIELD_W'(want.ovf), FIELD_W'(got.ovf));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[nearest_neighbor_path_order] ERROR");
            $finish;
        end
    end

    task automatic add_point(int x, int y, int z, bit fin);
        point_t p;
        p.x = x[FIELD_W-1:0];
        p.y = y[FIELD_W-1:0];
        p.z = z[FIELD_W-1:0];
        p.fin = fin;
        feed_q.insert(feed_q.size(), p);
        queued++;
    endtask

    function automatic int pick_coord(spread_t spread);
        int r;
        case (spread)
            SPREAD_FULL: r = $urandom_range(65535) - 32768;
            // coarse grid gives many equal distances
            SPREAD_GRID: r = ($urandom_range(4) - 2) * 256;
            default: begin
                r = $urandom_range(2);
                r = (r == 0) ? -32768 : (r == 1) ? 32767 : 0;
            end
        endcase
        return r;
    endfunction

    task automatic add_set(int n);
        spread_t spread;
        int      r;
        r = $urandom_range(9);
        spread = (r < 5) ? SPREAD_FULL : (r < 8) ? SPREAD_GRID : SPREAD_EDGE;
        for (int i = 0; i < n; i++) begin
            add_point(pick_coord(spread), pick_coord(spread), pick_coord(spread), i == n - 1);
        end
    endtask

    task automatic wait_sent();
        while (feed_q.size() != 0 || s_tvalid) @(negedge aclk);
    endtask

    // random sets of mostly small size, now and then full or overfull
    task automatic run_phase(int idle, int stall, int count);
        int goal;
        int r;
        idle_pct = idle;
        stall_pct = stall;
        goal = queued + count;
        while (queued < goal) begin
            r = $urandom_range(99);
            if (r < 8) add_set($urandom_range(17, 19));
            else if (r < 18) add_set($urandom_range(12, 16));
            else add_set($urandom_range(1, 6));
        end
        wait_sent();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // single point at the coordinate extremes
        add_point(-32768, 32767, -32768, 1'b1);
        // equal distances and a point on the origin
        add_point(256, 0, 0, 1'b0);
        add_point(0, 256, 0, 1'b0);
        add_point(-256, 0, 0, 1'b0);
        add_point(256, 0, 0, 1'b0);
        add_point(0, 0, 0, 1'b1);
        // opposite corners of the coordinate range
        add_point(32767, 32767, 32767, 1'b0);
        add_point(-32768, -32768, -32768, 1'b0);
        add_point(0, 0, 0, 1'b0);
        add_point(32767, -32768, 1, 1'b1);
        // overfull set, final point itself dropped
        add_set(18);
        // exactly at capacity
        add_set(CAPACITY);

        run_phase(0, 0, 14);
        run_phase(67, 0, 14);
        run_phase(0, 67, 14);
        run_phase(13, 13, 14);

        // long hold-off on the output while sets keep coming
        idle_pct = 0;
        stall_pct = 0;
        hold_asked++;
        add_set(5);
        add_set(5);
        add_set(4);
        wait_sent();

        while (tour_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        if (err_cnt == 0 && tour_q.size() == 0) begin
            $display("[nearest_neighbor_path_order] OK");
        end else begin
            $display("[nearest_neighbor_path_order] ERROR");
        end
        $finish;
    end

endmodule
